// File: rtl/core/sha256_pkg.sv
package sha256_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } sha_state_t;

  // controller -> datapath
  typedef struct packed {
    logic       take_byte;   // write byte into buffer, bump fill/length
    logic       pad_start;   // finish accepted: padding starts at current fill
    logic       pad_fill;    // write one padding byte at pad index
    logic       load_w;      // load schedule from buffer byte by byte
    logic       start_round; // copy chain into working vars
    logic       do_round;
    logic       add_chain;
    logic       restart;
    logic       emit_next;
  } sha_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;        // byte taken fills the buffer to 64
    logic load_done;
    logic round_done;
    logic pad_done;    // padding pass finished
    logic pad_two;     // padding needs second block
    logic emit_last;
  } sha_stat_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: rtl/core/sha256_ctrl.sv
module sha256_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  sha256_pkg::in_beat_t in_data,
  output logic                 in_stall,
  input  logic                 out_busy,   // output register holds an untaken beat
  output sha256_pkg::sha_cmd_t cmd,
  input  sha256_pkg::sha_stat_t stat
);
  import sha256_pkg::*;

  sha_state_t state_r, state_nxt;
  logic       fin_r, fin_nxt;   // current compression belongs to finish
  logic       acc;

  assign in_stall = (state_r != ST_IDLE);
  assign acc      = in_valid && (state_r == ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_data.cmd == CMD_FINISH) begin
            state_nxt = ST_PAD;
            fin_nxt   = 1'b1;
          end else begin
            fin_nxt = 1'b0;
            if (stat.full) state_nxt = ST_LOAD;
          end
        end
      end
      ST_PAD:   if (stat.pad_done) state_nxt = ST_LOAD;
      ST_LOAD:  if (stat.load_done) state_nxt = ST_ROUND;
      ST_ROUND: if (stat.round_done) state_nxt = ST_ADD;
      ST_ADD: begin
        if (!fin_r) state_nxt = ST_IDLE;
        else if (stat.pad_two) state_nxt = ST_PAD;
        else state_nxt = ST_EMIT;
      end
      ST_EMIT:  if (!out_busy && stat.emit_last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.take_byte = acc && (in_data.cmd == CMD_ABSORB);
        cmd.pad_start = acc && (in_data.cmd == CMD_FINISH);
      end
      ST_PAD:   cmd.pad_fill = 1'b1;
      ST_LOAD: begin
        cmd.load_w      = 1'b1;
        cmd.start_round = stat.load_done;
      end
      ST_ROUND: cmd.do_round = 1'b1;
      ST_ADD:   cmd.add_chain = 1'b1;
      ST_EMIT: begin
        cmd.emit_next = !out_busy;
        cmd.restart   = !out_busy && stat.emit_last;
      end
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

// File: rtl/core/sha256_datapath.sv
module sha256_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha256_pkg::in_beat_t  in_data,
  input  sha256_pkg::sha_cmd_t  cmd,
  output sha256_pkg::sha_stat_t stat,
  input  logic                  out_stall,
  output logic                  out_valid,
  output sha256_pkg::out_beat_t out_data
);
  import sha256_pkg::*;

  // block buffer: one byte written and one byte read per cycle
  logic [7:0]  buf_mem [64];
  logic [7:0]  rd_byte_r;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_byte;
  logic        wr_en;
  logic [5:0]  rd_addr;

  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [5:0]  pad_idx_r, pad_idx_nxt;
  logic        pad_first_r, pad_first_nxt; // first padding byte is 0x80
  logic        pad_two_r, pad_two_nxt;
  logic        pad_done;

  // load sequencer: 64 byte reads, read data registered
  logic [6:0]  ld_cnt_r, ld_cnt_nxt;
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] h_r [8];
  logic [31:0] h_nxt [8];
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  emit_r, emit_nxt;
  logic        ov_r, ov_nxt;
  out_beat_t   od_r, od_nxt;

  logic [31:0] s0, s1, wnew, t1, t2, ch, maj, ep0, ep1;

  // buffer write: absorbed byte at fill, or padding byte at pad index
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_r;
    wr_byte = in_data.data_byte;
    if (cmd.take_byte) begin
      wr_en = 1'b1;
    end else if (cmd.pad_fill) begin
      wr_en   = 1'b1;
      wr_addr = pad_idx_r;
      if (pad_first_r) wr_byte = 8'h80;
      else if (pad_two_r || pad_idx_r < 6'd56) wr_byte = 8'h00;
      else wr_byte = bits_r[8'd63 - {2'b0, pad_idx_r[2:0], 3'b0} -: 8];
    end
  end

  assign pad_done = cmd.pad_fill && (pad_idx_r == 6'd63);
  assign rd_addr  = ld_cnt_r[5:0];

  always_ff @(posedge clk) begin
    if (wr_en) buf_mem[wr_addr] <= wr_byte;
    rd_byte_r <= buf_mem[rd_addr];
  end

  // message schedule and round function
  assign s0  = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1  = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wnew = s1 + w_r[9] + s0 + w_r[0];
  assign ep1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
  assign ep0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1  = v_r[7] + ep1 + ch + ROUND_K[rnd_r] + w_r[0];
  assign t2  = ep0 + maj;

  always_comb begin
    fill_nxt      = fill_r;
    bits_nxt      = bits_r;
    pad_idx_nxt   = pad_idx_r;
    pad_first_nxt = pad_first_r;
    pad_two_nxt   = pad_two_r;
    ld_cnt_nxt    = ld_cnt_r;
    w_nxt         = w_r;
    v_nxt         = v_r;
    h_nxt         = h_r;
    rnd_nxt       = rnd_r;
    emit_nxt      = emit_r;
    ov_nxt        = ov_r;
    od_nxt        = od_r;

    if (cmd.take_byte) begin
      fill_nxt = fill_r + 6'd1;
      bits_nxt = bits_r + 64'd8;
    end

    // finish accepted: padding starts at current fill
    if (cmd.pad_start) begin
      pad_idx_nxt = fill_r;
      pad_two_nxt = (fill_r >= 6'd56);
    end

    // padding pass: sweeps index to 63
    if (cmd.pad_fill) begin
      pad_first_nxt = 1'b0;
      pad_idx_nxt   = pad_idx_r + 6'd1;
      if (pad_done) fill_nxt = 6'd0;
    end

    // schedule load: byte k arrives in the cycle after its read
    if (cmd.load_w && ld_cnt_r != 7'd0) begin
      // shift byte into the word being assembled: word (k-1)/4
      w_nxt[4'(({1'b0, ld_cnt_r} - 8'd1) >> 2)] =
        {w_r[4'(({1'b0, ld_cnt_r} - 8'd1) >> 2)][23:0], rd_byte_r};
    end
    if (cmd.load_w) ld_cnt_nxt = ld_cnt_r + 7'd1;
    if (cmd.start_round) begin
      ld_cnt_nxt = '0;
      v_nxt      = h_r;
      rnd_nxt    = '0;
    end

    if (cmd.do_round) begin
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
      for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i + 1];
      w_nxt[15] = wnew;
      rnd_nxt = rnd_r + 6'd1;
    end

    if (cmd.add_chain) begin
      for (int i = 0; i < 8; i++) h_nxt[i] = h_r[i] + v_r[i];
      // second padding block: zeros then length
      pad_idx_nxt = '0;
      pad_two_nxt = 1'b0;
    end

    // output register
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (cmd.emit_next) begin
      ov_nxt             = 1'b1;
      od_nxt.digest_word = h_r[emit_r];
      od_nxt.word_index  = emit_r;
      od_nxt.last_word   = (emit_r == 3'd7);
      emit_nxt           = emit_r + 3'd1;
    end
    if (cmd.restart) begin
      for (int i = 0; i < 8; i++) h_nxt[i] = INIT_H[i];
      fill_nxt      = '0;
      bits_nxt      = '0;
      pad_first_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      bits_r      <= '0;
      pad_idx_r   <= '0;
      pad_first_r <= 1'b1;
      pad_two_r   <= 1'b0;
      ld_cnt_r    <= '0;
      rnd_r       <= '0;
      emit_r      <= '0;
      ov_r        <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
    end else begin
      fill_r      <= fill_nxt;
      bits_r      <= bits_nxt;
      pad_idx_r   <= pad_idx_nxt;
      pad_first_r <= pad_first_nxt;
      pad_two_r   <= pad_two_nxt;
      ld_cnt_r    <= ld_cnt_nxt;
      rnd_r       <= rnd_nxt;
      emit_r      <= emit_nxt;
      ov_r        <= ov_nxt;
      h_r         <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r  <= w_nxt;
    v_r  <= v_nxt;
    od_r <= od_nxt;
  end

  assign stat.full       = cmd.take_byte && (fill_r == 6'd63);
  assign stat.load_done  = cmd.load_w && (ld_cnt_r == 7'd64);
  assign stat.round_done = cmd.do_round && (rnd_r == 6'd63);
  assign stat.pad_done   = pad_done;
  assign stat.pad_two    = !pad_first_r && pad_two_r;
  assign stat.emit_last  = (emit_r == 3'd7);

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// File: rtl/core/sha256_stream_hasher_unit.sv
// SHA-256 stream hasher.
// Input channel (in_valid/in_stall/in_data): one beat per message byte
// (cmd absorb) or a finish beat (cmd finish). Output channel
// (out_valid/out_stall/out_data): eight digest word beats after each
// finish, word_index 0..7, last_word set on the eighth.
// The 64th byte of a block starts a compression: schedule load,
// 64 rounds and chain add, run on the single round unit doing one
// round per cycle. A finish beat runs a padding sweep from the fill
// to byte 63 plus one compression (two if fewer than nine bytes of
// room remain), then one digest word per cycle unless stalled.
// in_stall is high whenever a beat is in work. When the receiver stalls,
// the output register holds its beat and the word sequencer waits.
// After the eighth word the hasher returns to the initial hash values.
// Reset (rst_n low, synchronous) restores the initial state; buffer
// contents are not cleared and are never read before being written.
module sha256_stream_hasher_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sha256_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sha256_pkg::out_beat_t out_data
);
  import sha256_pkg::*;

  sha_cmd_t  cmd;
  sha_stat_t stat;
  logic      out_busy;

  assign out_busy = out_valid && out_stall;

  sha256_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_busy (out_busy),
    .cmd      (cmd),
    .stat     (stat)
  );

  sha256_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: sim/sha256_stream_hasher_unit_test.sv
module sha256_stream_hasher_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sha256_pkg::*;

  localparam int NUM_RANDOM = 127;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  sha256_stream_hasher_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // round constants and initial hash, kept local to the predictor
  logic [31:0] k_tab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  logic [31:0] h_init [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // predictor state
  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  int          block_fill;
  logic [63:0] bit_count;

  out_beat_t digest_q[$];
  int errors = 0;
  int digests_seen = 0;
  int beats_sent = 0;
  bit long_hold = 1'b0;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1, ch, mj;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    v = hash_state;
    for (int t = 0; t < 64; t++) begin
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) + ch
         + k_tab[t] + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) + mj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic restart_hash();
    hash_state = h_init;
    block_fill = 0;
    bit_count = '0;
  endtask

  // update the predictor with one accepted beat
  task automatic hash_beat(in_beat_t b);
    out_beat_t o;
    if (b.cmd == CMD_ABSORB) begin
      msg_block[block_fill] = b.data_byte;
      bit_count += 64'd8;
      block_fill++;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end else begin
      msg_block[block_fill] = 8'h80;
      for (int i = block_fill + 1; i < 64; i++) msg_block[i] = 8'h00;
      if (block_fill >= 56) begin
        compress_block();
        for (int i = 0; i < 56; i++) msg_block[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) msg_block[56+i] = bit_count[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = hash_state[i];
        o.word_index = 3'(i);
        o.last_word = (i == 7);
        digest_q.push_back(o);
      end
      restart_hash();
    end
  endtask

  // stimulus store: beats plus, for directed rows, an optional known first word
  in_beat_t   stim_q[$];
  logic [31:0] known_q[$];
  bit          known_v[$];

  task automatic add_beat(logic c, logic [7:0] d);
    in_beat_t b;
    b.cmd = c;
    b.data_byte = d;
    stim_q.push_back(b);
  endtask

  task automatic add_message(int len);
    for (int i = 0; i < len; i++) add_beat(CMD_ABSORB, 8'($urandom_range(0, 255)));
    add_beat(CMD_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // directed rows: empty string digest, "abc", byte extremes
  typedef struct {
    logic        cmd;
    logic [7:0]  data;
    bit          has_known;
    logic [31:0] known_word0;
  } stim_row_t;

  stim_row_t directed_tab [11] = '{
    '{CMD_FINISH, 8'hff, 1'b1, 32'he3b0c442},
    '{CMD_ABSORB, 8'h61, 1'b0, 32'h0},
    '{CMD_ABSORB, 8'h62, 1'b0, 32'h0},
    '{CMD_ABSORB, 8'h63, 1'b0, 32'h0},
    '{CMD_FINISH, 8'h00, 1'b1, 32'hba7816bf},
    '{CMD_ABSORB, 8'h00, 1'b0, 32'h0},
    '{CMD_ABSORB, 8'hff, 1'b0, 32'h0},
    '{CMD_ABSORB, 8'haa, 1'b0, 32'h0},
    '{CMD_ABSORB, 8'h55, 1'b0, 32'h0},
    '{CMD_FINISH, 8'h5a, 1'b0, 32'h0},
    '{CMD_FINISH, 8'h00, 1'b1, 32'he3b0c442}
  };

  // sender
  initial begin
    in_beat_t b;
    int n_rand;
    int gap;
    foreach (directed_tab[i]) begin
      add_beat(directed_tab[i].cmd, directed_tab[i].data);
      known_v.push_back(directed_tab[i].has_known);
      known_q.push_back(directed_tab[i].known_word0);
    end
    // padding boundaries: 55, 56, 63 and 64 bytes
    add_message(55); add_message(56); add_message(63); add_message(64);
    n_rand = 0;
    while (n_rand < NUM_RANDOM) begin
      int len;
      if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 70);
      else len = $urandom_range(0, 12);
      if (len > NUM_RANDOM - n_rand - 1) len = NUM_RANDOM - n_rand - 1;
      add_message(len);
      n_rand += len + 1;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (stim_q.size() > 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      b = stim_q.pop_front();
      in_valid <= 1'b1;
      in_data <= b;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      beats_sent++;
      hash_beat(b);
      if (known_v.size() > 0) begin
        if (known_v.pop_front() && digest_q.size() >= 8) begin
          logic [31:0] kw;
          kw = known_q.pop_front();
          if (digest_q[digest_q.size() - 8].digest_word !== kw) begin
            $display("%0t: known digest mismatch expected %h actual %h",
                     $time, kw, digest_q[digest_q.size() - 8].digest_word);
            errors++;
          end
        end else void'(known_q.pop_front());
      end
    end
    in_valid <= 1'b0;
    while (digest_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d beats, checked %0d digests incl. empty, abc and pad boundaries.",
             beats_sent, digests_seen);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // receiver stall pattern, with one long hold while the sender keeps going
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (!long_hold && digests_seen >= 6) begin
        long_hold = 1'b1;
        out_stall <= 1'b1;
        for (int c = 0; c < 600; c++) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
    end
  end

  // checker
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected beat expected none actual %h", $time, out_data);
        errors++;
      end else begin
        want = digest_q.pop_front();
        if (out_data.digest_word !== want.digest_word) begin
          $display("%0t: digest_word expected %h actual %h", $time,
                   want.digest_word, out_data.digest_word);
          errors++;
        end
        if (out_data.word_index !== want.word_index) begin
          $display("%0t: word_index expected %0d actual %0d", $time,
                   want.word_index, out_data.word_index);
          errors++;
        end
        if (out_data.last_word !== want.last_word) begin
          $display("%0t: last_word expected %b actual %b", $time,
                   want.last_word, out_data.last_word);
          errors++;
        end
        if (want.last_word) digests_seen++;
      end
    end
  end

  initial begin
    hash_state = h_init;
    block_fill = 0;
    bit_count = '0;
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
  end

  // watchdog
  initial begin
    #8ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
